@@ rtl/core/pl_pkg.sv @@
package pl_pkg;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;

  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic load;      // latch the request
    logic rd_en;     // issue a RAM read
    logic rd_src;    // 0: read at position, 1: read the shift source
    logic wr_en;     // write the RAM
    logic wr_fill;   // 1: write the new value at position, 0: write the shifted word
    logic idx_init;  // start the shift index
    logic idx_step;  // advance the shift index
    logic capture;   // keep the word read at position
    logic emit;      // load the result registers and commit the count
  } pl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic req_ok;
    logic is_insert;
    logic is_read;
    logic more;      // another entry still has to move
  } pl_sts_t;

endpackage

@@ rtl/core/pl_ram.sv @@
module pl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/pl_ctrl.sv @@
module pl_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  pl_pkg::pl_sts_t  sts,
  output pl_pkg::pl_cmd_t  cmd
);
  import pl_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_GET   = 7'b0000100,
    S_SH_RD = 7'b0001000,
    S_SH_WR = 7'b0010000,
    S_FILL  = 7'b0100000,
    S_DONE  = 7'b1000000
  } pl_state_t;

  pl_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.req_ok) begin
          state_nxt = S_DONE;
        end else if (sts.is_insert) begin
          cmd.idx_init = 1'b1;
          state_nxt    = S_SH_RD;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = 1'b0;
          state_nxt  = S_GET;
        end
      end
      S_GET: begin
        cmd.capture = 1'b1;
        if (sts.is_read) begin
          state_nxt = S_DONE;
        end else begin
          cmd.idx_init = 1'b1;
          state_nxt    = S_SH_RD;
        end
      end
      S_SH_RD: begin
        if (sts.more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = 1'b1;
          state_nxt  = S_SH_WR;
        end else if (sts.is_insert) begin
          state_nxt = S_FILL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SH_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_fill  = 1'b0;
        cmd.idx_step = 1'b1;
        state_nxt    = S_SH_RD;
      end
      S_FILL: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_fill = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

@@ rtl/core/pl_dp.sv @@
module pl_dp #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [pl_pkg::ACTION_W-1:0]   in_action,
  input  logic [pl_pkg::POS_W-1:0]      in_position,
  input  logic signed [pl_pkg::VALUE_W-1:0] in_value,
  input  pl_pkg::pl_cmd_t               cmd,
  output pl_pkg::pl_sts_t               sts,
  output logic                          ram_re,
  output logic [AW-1:0]                 ram_raddr,
  input  logic [pl_pkg::VALUE_W-1:0]    ram_rdata,
  output logic                          ram_we,
  output logic [AW-1:0]                 ram_waddr,
  output logic [pl_pkg::VALUE_W-1:0]    ram_wdata,
  output logic                          out_strobe,
  output logic signed [pl_pkg::VALUE_W-1:0] out_result_value,
  output logic [pl_pkg::STATUS_W-1:0]   out_status,
  output logic [pl_pkg::COUNT_W-1:0]    out_entry_count
);
  import pl_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [ACTION_W-1:0] act_r;
  logic [POS_W-1:0]    pos_r;
  logic [VALUE_W-1:0]  val_r;
  logic [VALUE_W-1:0]  got_r;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic                strobe_r;
  logic [VALUE_W-1:0]  res_r, res_nxt;
  logic [STATUS_W-1:0] st_r;
  logic [COUNT_W-1:0]  ocnt_r;

  logic [CMP_W-1:0]    pos_x, cnt_x, idx_x, pos_p1, cnt_nxt_x;
  logic [CNT_W-1:0]    idx_m1;
  logic [STATUS_W-1:0] chk;
  logic                is_ins;

  assign pos_x     = CMP_W'(pos_r);
  assign cnt_x     = CMP_W'(cnt_r);
  assign idx_x     = CMP_W'(idx_r);
  assign pos_p1    = pos_x + 1'b1;
  assign idx_m1    = idx_r - 1'b1;
  assign is_ins    = (act_r == ACT_INSERT);
  assign cnt_nxt_x = CMP_W'(cnt_nxt);

  // Fullness before position for insert, emptiness before position for remove and read; other codes are a bad position
  always_comb begin
    case (act_r)
      ACT_INSERT: begin
        if (cnt_x >= CMP_W'(CAPACITY)) begin
          chk = ST_FULL;
        end else if (pos_x > cnt_x) begin
          chk = ST_BADPOS;
        end else begin
          chk = ST_OK;
        end
      end
      ACT_REMOVE, ACT_READ: begin
        if (cnt_r == '0) begin
          chk = ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          chk = ST_BADPOS;
        end else begin
          chk = ST_OK;
        end
      end
      default: begin
        chk = ST_BADPOS;
      end
    endcase
  end

  assign sts.req_ok    = (chk == ST_OK);
  assign sts.is_insert = is_ins;
  assign sts.is_read   = (act_r == ACT_READ);
  assign sts.more      = is_ins ? (idx_x > pos_x) : (idx_x < cnt_x);

  // Insert walks down moving idx-1 to idx; remove walks up moving idx to idx-1
  assign ram_re    = cmd.rd_en;
  assign ram_raddr = !cmd.rd_src ? pos_x[AW-1:0] :
                     (is_ins ? idx_m1[AW-1:0] : idx_r[AW-1:0]);
  assign ram_we    = cmd.wr_en;
  assign ram_waddr = cmd.wr_fill ? pos_x[AW-1:0] :
                     (is_ins ? idx_r[AW-1:0] : idx_m1[AW-1:0]);
  assign ram_wdata = cmd.wr_fill ? val_r : ram_rdata;

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_init) begin
      idx_nxt = is_ins ? cnt_r : pos_p1[CNT_W-1:0];
    end else if (cmd.idx_step) begin
      idx_nxt = is_ins ? idx_m1 : (idx_r + 1'b1);
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (chk == ST_OK) begin
      if (act_r == ACT_INSERT) begin
        cnt_nxt = cnt_r + 1'b1;
      end else if (act_r == ACT_REMOVE) begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  assign res_nxt = ((chk == ST_OK) && !is_ins) ? got_r : '0;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_action;
      pos_r <= in_position;
      val_r <= in_value;
    end
    if (cmd.capture) begin
      got_r <= ram_rdata;
    end
    idx_r <= idx_nxt;
    if (cmd.emit) begin
      res_r  <= res_nxt;
      st_r   <= chk;
      ocnt_r <= cnt_nxt_x[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.emit;
      if (cmd.emit) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  assign out_strobe       = strobe_r;
  assign out_result_value = res_r;
  assign out_status       = st_r;
  assign out_entry_count  = ocnt_r;

endmodule

@@ rtl/core/positional_list_insert_remove_top.sv @@
// Steps: a rejected request goes from check to done; read first reads the entry at position;
//   insert moves later entries up, then writes the value; remove reads, then moves later ones down.
// Each moved entry takes a read and a write through the one-read-port RAM.
// Throughput: one request at a time; start is taken again once busy drops, and the
//   result is shown for one cycle with out_strobe (the receiver cannot stall).
// Reset empties the list (count zero) at once; entry contents are kept and need no clearing.
module positional_list_insert_remove_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [pl_pkg::ACTION_W-1:0]       in_action,
  input  logic [pl_pkg::POS_W-1:0]          in_position,
  input  logic signed [pl_pkg::VALUE_W-1:0] in_value,
  output logic                              out_strobe,
  output logic signed [pl_pkg::VALUE_W-1:0] out_result_value,
  output logic [pl_pkg::STATUS_W-1:0]       out_status,
  output logic [pl_pkg::COUNT_W-1:0]        out_entry_count
);
  import pl_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  pl_cmd_t            cmd;
  pl_sts_t            sts;
  logic               ram_re, ram_we;
  logic [AW-1:0]      ram_raddr, ram_waddr;
  logic [VALUE_W-1:0] ram_rdata, ram_wdata;

  pl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  pl_dp #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_action        (in_action),
    .in_position      (in_position),
    .in_value         (in_value),
    .cmd              (cmd),
    .sts              (sts),
    .ram_re           (ram_re),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .out_strobe       (out_strobe),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count)
  );

  pl_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted beat");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != ST_OK) |-> (out_result_value == '0))
    else $error("rejected request returned a nonzero value");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (32'(out_entry_count) <= CAPACITY))
    else $error("entry count beyond capacity");

  a_ram_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.rd_en && cmd.wr_en))
    else $error("RAM read and write issued in the same cycle");
`endif

endmodule

@@ tb/tb_positional_list_insert_remove_top.sv @@
`timescale 1ns / 1ps

module tb_positional_list_insert_remove_top;
  import pl_pkg::*;

  localparam int CAPACITY = 64;
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 2 * CAPACITY + 20;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [STATUS_W-1:0]       status;
    logic [COUNT_W-1:0]        entry_count;
  } list_result_t;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic [ACTION_W-1:0]        in_action;
  logic [POS_W-1:0]           in_position;
  logic signed [VALUE_W-1:0]  in_value;
  logic                       out_strobe;
  logic signed [VALUE_W-1:0]  out_result_value;
  logic [STATUS_W-1:0]        out_status;
  logic [COUNT_W-1:0]         out_entry_count;

  // Predicted list contents and count
  logic signed [VALUE_W-1:0]  list_mem [CAPACITY];
  logic [COUNT_W-1:0]         list_count;
  list_result_t               pending_results[$];

  bit   idle_en;
  int   fail_count;
  int   beats_in;
  int   results_seen;
  int   status_seen [4];
  int   quiet_cycles;

  positional_list_insert_remove_top #(.CAPACITY(CAPACITY)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_position      (in_position),
    .in_value         (in_value),
    .out_strobe       (out_strobe),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic list_result_t predict_list_op(logic [ACTION_W-1:0] act,
                                                   logic [POS_W-1:0] pos,
                                                   logic signed [VALUE_W-1:0] val);
    list_result_t r;
    int i;
    r.value  = '0;
    r.status = ST_OK;
    case (act)
      ACT_INSERT: begin
        if (list_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (pos > list_count) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = int'(list_count); i > int'(pos); i--)
            list_mem[IDX_W'(i)] = list_mem[IDX_W'(i-1)];
          list_mem[IDX_W'(pos)] = val;
          list_count++;
        end
      end
      ACT_REMOVE, ACT_READ: begin
        if (list_count == 0) begin
          r.status = ST_EMPTY;
        end else if (pos >= list_count) begin
          r.status = ST_BADPOS;
        end else begin
          r.value = list_mem[IDX_W'(pos)];
          if (act == ACT_REMOVE) begin
            for (i = int'(pos) + 1; i < int'(list_count); i++)
              list_mem[IDX_W'(i-1)] = list_mem[IDX_W'(i)];
            list_count--;
          end
        end
      end
      default: r.status = ST_BADPOS;
    endcase
    r.entry_count = list_count;
    return r;
  endfunction

  // Check results first, then record the beat accepted at this edge
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      results_seen++;
      status_seen[out_status]++;
      if (pending_results.size() == 0) begin
        $error("result with nothing outstanding: value %0d status %0d count %0d",
               out_result_value, out_status, out_entry_count);
        fail_count++;
      end else begin
        if (out_result_value !== pending_results[0].value) begin
          $error("result_value: expected %0d, got %0d",
                 pending_results[0].value, out_result_value);
          fail_count++;
        end
        if (out_status !== pending_results[0].status) begin
          $error("status: expected %0d, got %0d", pending_results[0].status, out_status);
          fail_count++;
        end
        if (out_entry_count !== pending_results[0].entry_count) begin
          $error("entry_count: expected %0d, got %0d",
                 pending_results[0].entry_count, out_entry_count);
          fail_count++;
        end
        void'(pending_results.pop_front());
      end
    end
    if (rst_n && start && !busy) begin
      pending_results.push_back(predict_list_op(in_action, in_position, in_value));
      beats_in++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no progress for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Present one beat and hold it until accepted
  task automatic send_beat(logic [ACTION_W-1:0] act, logic [POS_W-1:0] pos,
                           logic signed [VALUE_W-1:0] val);
    if (idle_en && $urandom_range(99, 0) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    start       <= 1'b1;
    in_action   <= act;
    in_position <= pos;
    in_value    <= val;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_empty_list_errors();
    send_beat(ACT_READ, 7'd0, 32'sd0);
    send_beat(ACT_REMOVE, 7'd0, 32'sd0);
    send_beat(ACT_REMOVE, 7'd5, 32'sd0);
    send_beat(ACT_INSERT, 7'd1, 32'sd11);
    send_beat(ACT_UNUSED, 7'd0, 32'sd0);
    send_beat(ACT_INSERT, 7'd127, -32'sd1);
  endtask

  task automatic test_edge_values();
    int i;
    send_beat(ACT_INSERT, 7'd0, 32'sh8000_0000);
    send_beat(ACT_INSERT, 7'd1, 32'sh7FFF_FFFF);
    send_beat(ACT_INSERT, 7'd0, -32'sd1);
    send_beat(ACT_INSERT, 7'd1, 32'sd0);
    send_beat(ACT_INSERT, 7'd4, 32'sh5555_5555);
    send_beat(ACT_INSERT, 7'd2, 32'shAAAA_AAAA);
    for (i = 0; i < 6; i++) send_beat(ACT_READ, i[POS_W-1:0], 32'sd0);
    send_beat(ACT_READ, 7'd6, 32'sd0);
    send_beat(ACT_READ, 7'd127, 32'sd0);
    send_beat(ACT_REMOVE, 7'd2, 32'sd0);
    send_beat(ACT_REMOVE, 7'd0, 32'sd0);
    send_beat(ACT_REMOVE, 7'd3, 32'sd0);
    send_beat(ACT_REMOVE, 7'd3, 32'sd0);
    send_beat(ACT_UNUSED, 7'd1, 32'sd99);
  endtask

  task automatic test_fill_to_capacity();
    while (list_count < CAPACITY)
      send_beat(ACT_INSERT, POS_W'($urandom_range(list_count, 0)), $urandom);
    send_beat(ACT_INSERT, 7'd0, 32'sd1);
    send_beat(ACT_INSERT, 7'd100, 32'sd2);
    send_beat(ACT_READ, 7'd63, 32'sd0);
    send_beat(ACT_READ, 7'd64, 32'sd0);
    send_beat(ACT_REMOVE, 7'd63, 32'sd0);
    send_beat(ACT_INSERT, 7'd64, 32'sd3);
    send_beat(ACT_INSERT, 7'd63, $urandom);
    send_beat(ACT_REMOVE, 7'd0, 32'sd0);
  endtask

  // Mostly legal requests; grow toward full, then shrink toward empty, and repeat
  task automatic test_random_mix(int n);
    int k;
    int r;
    bit grow;
    logic [ACTION_W-1:0] act;
    logic [POS_W-1:0] pos;
    grow = 1'b1;
    for (k = 0; k < n; k++) begin
      if (list_count == CAPACITY) grow = 1'b0;
      if (list_count == 0) grow = 1'b1;
      r = $urandom_range(99, 0);
      if (r < 4) begin
        act = ACT_UNUSED;
        pos = POS_W'($urandom_range(127, 0));
      end else if (r < 14) begin
        act = ACTION_W'($urandom_range(2, 0));
        pos = POS_W'($urandom_range(127, 0));
      end else begin
        r = $urandom_range(99, 0);
        if (r < (grow ? 60 : 25)) act = ACT_INSERT;
        else if (r < 80) act = ACT_REMOVE;
        else act = ACT_READ;
        if (act == ACT_INSERT) pos = POS_W'($urandom_range(list_count, 0));
        else if (list_count == 0) pos = POS_W'($urandom_range(3, 0));
        else pos = POS_W'($urandom_range(list_count - 1, 0));
      end
      send_beat(act, pos, $urandom);
    end
  endtask

  task automatic test_pause_until_drained();
    int k;
    for (k = 0; k < 6; k++) begin
      test_random_mix($urandom_range(6, 2));
      wait_drained();
    end
  endtask

  task automatic test_drain_to_empty();
    while (list_count != 0)
      send_beat(ACT_REMOVE, POS_W'($urandom_range(list_count - 1, 0)), $urandom);
    send_beat(ACT_REMOVE, 7'd0, 32'sd0);
    send_beat(ACT_READ, 7'd127, 32'sd0);
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_action    = ACT_INSERT;
    in_position  = '0;
    in_value     = '0;
    list_count   = '0;
    idle_en      = 1'b1;
    fail_count   = 0;
    beats_in     = 0;
    results_seen = 0;
    quiet_cycles = 0;
    status_seen  = '{default: 0};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_list_errors();
    test_edge_values();
    test_fill_to_capacity();
    test_random_mix(570);
    idle_en = 1'b0;
    test_random_mix(200);
    idle_en = 1'b1;
    test_pause_until_drained();
    test_drain_to_empty();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d requests through insert, remove, read and the unused code; %0d results",
             beats_in, results_seen);
    $display("Status seen: ok %0d, full %0d, bad position %0d, empty %0d",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_BADPOS],
             status_seen[ST_EMPTY]);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      if (pending_results.size() != 0) begin
        $error("%0d results never arrived", pending_results.size());
      end
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
